[sv/vtlv_pkg.sv]
// shared types and constants for the vendor element attribute parser
// no dependencies; imported by every module of the block
package vtlv_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_EXPECTED_TYPE    = 3'd0;
  localparam logic [2:0] REG_ID_MCS_LOW_RATE  = 3'd1;
  localparam logic [2:0] REG_ID_SHORT_GUARD   = 3'd2;
  localparam logic [2:0] REG_ID_DOUBLE_LTF    = 3'd3;
  localparam logic [2:0] REG_ID_MCS_HIGH_RATE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HDR   = 2'd1;
  localparam logic [1:0] ST_MCS_SHORT = 2'd2;

  // attribute walk phases
  localparam logic [1:0] PH_ID  = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  localparam logic [2:0] HDR_LAST_IDX = 3'd3;
  localparam logic [2:0] HDR_DONE_IDX = 3'd4;

  localparam logic [7:0] LEN_MIN_LOW_RATE    = 8'd1;
  localparam logic [7:0] LEN_MIN_DOUBLE_LTF  = 8'd1;
  localparam logic [7:0] LEN_MIN_SHORT_GUARD = 8'd3;
  localparam logic [7:0] LEN_MIN_HIGH_RATE   = 8'd2;

  localparam int unsigned OUT_W = 40;

  typedef struct packed {
    logic [7:0] expected_type;
    logic [7:0] id_mcs_low_rate;
    logic [7:0] id_short_guard;
    logic [7:0] id_double_ltf;
    logic [7:0] id_mcs_high_rate;
  } cfg_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [15:0] mcs_cap;
    logic        mcs_valid;
    logic [1:0]  sgi_cap;
    logic        sgi_valid;
    logic [7:0]  ltf_cap;
    logic        ltf_valid;
    logic [7:0]  vht_cap;
    logic        vht_valid;
    logic [1:0]  status;
  } result_t;

endpackage

[sv/vtlv_in_stage.sv]
// input register stage of the attribute parser
// depends on vtlv_pkg
module vtlv_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  vtlv_pkg::byte_beat_t in_beat,
  input  logic                out_free,
  output logic                beat_fire,
  output vtlv_pkg::byte_beat_t beat
);
  import vtlv_pkg::*;

  logic       valid_r;
  byte_beat_t beat_r;

  // a non-last byte never needs the result slot
  assign beat_fire = valid_r && (!beat_r.last_byte || out_free);
  assign in_tready = !valid_r || beat_fire;
  assign beat      = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_r <= in_beat;
    end
  end

endmodule

[sv/vtlv_attr_walk.sv]
// header check, attribute walk and capture registers
// depends on vtlv_pkg
module vtlv_attr_walk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtlv_pkg::cfg_t       cfg,
  input  logic                 beat_fire,
  input  vtlv_pkg::byte_beat_t beat,
  output vtlv_pkg::result_t    result
);
  import vtlv_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        hdr_bad_r, hdr_bad_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  vb0_r, vb0_nxt;
  logic [7:0]  vb1_r, vb1_nxt;
  logic [3:0]  vld_r, vld_nxt;       // vht, ltf, sgi, mcs
  logic [7:0]  vht_r, vht_nxt;
  logic [7:0]  ltf_r, ltf_nxt;
  logic [1:0]  sgi_r, sgi_nxt;
  logic [15:0] mcs_r, mcs_nxt;
  logic        done_r, done_nxt;
  logic        err_r, err_nxt;
  logic        commit;
  logic [7:0]  commit_len;
  logic [7:0]  pos;
  logic [7:0]  b;

  assign b   = beat.data_byte;
  assign pos = len_r - rem_r;

  always_comb begin
    idx_nxt     = idx_r;
    phase_nxt   = phase_r;
    hdr_bad_nxt = hdr_bad_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    vb0_nxt     = vb0_r;
    vb1_nxt     = vb1_r;
    commit      = 1'b0;
    commit_len  = len_r;

    if (idx_r < HDR_LAST_IDX) begin
      if (beat.last_byte) begin
        hdr_bad_nxt = 1'b1;
      end
      idx_nxt = idx_r + 3'd1;
    end else if (idx_r == HDR_LAST_IDX) begin
      if (b != cfg.expected_type) begin
        hdr_bad_nxt = 1'b1;
      end
      idx_nxt = HDR_DONE_IDX;
    end else if (!hdr_bad_r) begin
      case (phase_r)
        PH_LEN: begin
          len_nxt    = b;
          rem_nxt    = b;
          commit_len = b;
          if (b == 8'd0) begin
            commit    = 1'b1;
            phase_nxt = PH_ID;
          end else begin
            phase_nxt = PH_VAL;
          end
        end
        PH_VAL: begin
          if (pos == 8'd0) vb0_nxt = b;
          if (pos == 8'd1) vb1_nxt = b;
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == 8'd0) begin
            commit    = 1'b1;
            phase_nxt = PH_ID;
          end
        end
        default: begin
          id_nxt    = b;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  // commit of a complete attribute
  always_comb begin
    vld_nxt  = vld_r;
    vht_nxt  = vht_r;
    ltf_nxt  = ltf_r;
    sgi_nxt  = sgi_r;
    mcs_nxt  = mcs_r;
    done_nxt = done_r;
    err_nxt  = err_r;
    if (commit) begin
      if (id_r == cfg.id_mcs_low_rate && commit_len >= LEN_MIN_LOW_RATE) begin
        vht_nxt    = vb0_nxt;
        vld_nxt[0] = 1'b1;
      end else if (id_r == cfg.id_double_ltf && commit_len >= LEN_MIN_DOUBLE_LTF) begin
        ltf_nxt    = vb0_nxt;
        vld_nxt[1] = 1'b1;
      end else if (id_r == cfg.id_short_guard && commit_len >= LEN_MIN_SHORT_GUARD) begin
        sgi_nxt    = {vb1_nxt[0], vb0_nxt[0]};
        vld_nxt[2] = 1'b1;
      end
      if (!done_r && id_r == cfg.id_mcs_high_rate) begin
        done_nxt = 1'b1;
        if (commit_len < LEN_MIN_HIGH_RATE) begin
          err_nxt = 1'b1;
        end else begin
          mcs_nxt    = {vb1_nxt, vb0_nxt};
          vld_nxt[3] = 1'b1;
        end
      end
    end
  end

  // result for a last byte; caps without a valid mark read as zero
  always_comb begin
    result = '0;
    if (hdr_bad_nxt) begin
      result.status = ST_BAD_HDR;
    end else begin
      result.status    = err_nxt ? ST_MCS_SHORT : ST_OK;
      result.vht_valid = vld_nxt[0];
      result.vht_cap   = vld_nxt[0] ? vht_nxt : 8'd0;
      result.ltf_valid = vld_nxt[1];
      result.ltf_cap   = vld_nxt[1] ? ltf_nxt : 8'd0;
      result.sgi_valid = vld_nxt[2];
      result.sgi_cap   = vld_nxt[2] ? sgi_nxt : 2'd0;
      result.mcs_valid = vld_nxt[3];
      result.mcs_cap   = vld_nxt[3] ? mcs_nxt : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      phase_r   <= PH_ID;
      hdr_bad_r <= 1'b0;
      vld_r     <= '0;
      done_r    <= 1'b0;
      err_r     <= 1'b0;
    end else if (beat_fire) begin
      if (beat.last_byte) begin
        idx_r     <= '0;
        phase_r   <= PH_ID;
        hdr_bad_r <= 1'b0;
        vld_r     <= '0;
        done_r    <= 1'b0;
        err_r     <= 1'b0;
      end else begin
        idx_r     <= idx_nxt;
        phase_r   <= phase_nxt;
        hdr_bad_r <= hdr_bad_nxt;
        vld_r     <= vld_nxt;
        done_r    <= done_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_fire) begin
      id_r  <= id_nxt;
      len_r <= len_nxt;
      rem_r <= rem_nxt;
      vb0_r <= vb0_nxt;
      vb1_r <= vb1_nxt;
      vht_r <= vht_nxt;
      ltf_r <= ltf_nxt;
      sgi_r <= sgi_nxt;
      mcs_r <= mcs_nxt;
    end
  end

endmodule

[sv/vtlv_out_stage.sv]
// result register toward the output stream
// depends on vtlv_pkg
module vtlv_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  vtlv_pkg::result_t         result,
  output logic                      out_free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [vtlv_pkg::OUT_W-1:0] out_tdata
);
  import vtlv_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

[sv/vendor_ie_tlv_capability_parser.sv]
// top level of the vendor element attribute parser
// depends on vtlv_pkg, vtlv_in_stage, vtlv_attr_walk, vtlv_out_stage
//
// Takes a vendor element body one byte per beat (three OUI bytes, the vendor
// type byte, then id/length/value attributes), tlast on the final byte. The
// type byte must match expected_type. Each attribute's first two value bytes
// are held and committed only once its last value byte lies inside the body.
// On the tlast beat one result beat comes out: status (0 ok, 1 short body or
// wrong type, 2 MCS12/13 attribute under two bytes) and the captured fields
// with valid marks; a field without its mark reads as zero. One byte is taken
// every cycle unless the input stalls; a byte goes input register -> walk
// logic -> result register. Only a last byte waits on the result register, so
// output backpressure stalls the input only when a result beat is still
// pending. Configuration is written through a plain write port; the user must
// write it only while no element is in flight, which the block itself does
// not enforce. Bad indexes are ignored.
module vendor_ie_tlv_capability_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [2] vht_valid, [10:3] vht_cap,
                                  // [11] ltf_valid, [19:12] ltf_cap, [20] sgi_valid,
                                  // [22:21] sgi_cap, [23] mcs_valid, [39:24] mcs_cap
);
  import vtlv_pkg::*;

  cfg_t       cfg_r;
  byte_beat_t in_beat;
  byte_beat_t beat;
  logic       beat_fire;
  logic       out_free;
  result_t    result;

  // register file, fixed reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_type    <= 8'd1;
      cfg_r.id_mcs_low_rate  <= 8'd2;
      cfg_r.id_short_guard   <= 8'd3;
      cfg_r.id_double_ltf    <= 8'd4;
      cfg_r.id_mcs_high_rate <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_TYPE:    cfg_r.expected_type    <= cfg_wdata;
        REG_ID_MCS_LOW_RATE:  cfg_r.id_mcs_low_rate  <= cfg_wdata;
        REG_ID_SHORT_GUARD:   cfg_r.id_short_guard   <= cfg_wdata;
        REG_ID_DOUBLE_LTF:    cfg_r.id_double_ltf    <= cfg_wdata;
        REG_ID_MCS_HIGH_RATE: cfg_r.id_mcs_high_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_beat.data_byte = in_tdata;
  assign in_beat.last_byte = in_tlast;

  vtlv_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_beat   (in_beat),
    .out_free  (out_free),
    .beat_fire (beat_fire),
    .beat      (beat)
  );

  vtlv_attr_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .beat_fire (beat_fire),
    .beat      (beat),
    .result    (result)
  );

  // a result is loaded only on the last byte of an element
  vtlv_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (beat_fire && beat.last_byte),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
